// ===== sv/jse_pkg.sv =====
// Package for the JSON string escaper: transaction types, character codes
// and the function that builds the escape sequence for one byte.
// No dependencies.
package jse_pkg;

    localparam int BUDGET_W = 13;
    localparam int SEQ_MAX = 6;
    localparam int LEN_W = 3;
    localparam int PADDR_W = 3;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 13'd1024;

    localparam logic [0:0] REG_OUT_BUDGET = 1'b0;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_U = 8'h75;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_F = 8'h46;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;
    localparam logic [15:0] CODE_REPLACE = 16'hFFFD;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_item;

    typedef logic [SEQ_MAX-1:0][7:0] t_chars;

    typedef struct packed {
        logic             load;
        t_chars           chars;
        logic [LEN_W-1:0] len;
    } t_seq;

    typedef struct packed {
        t_chars           chars;
        logic [LEN_W-1:0] len;
    } t_escape;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = CH_ZERO + {4'd0, nib};
        end else begin
            res = CH_UP_A + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

    function automatic t_escape build_escape(input logic [7:0] b);
        t_escape    res;
        logic [15:0] code;
        res.chars = '0;
        res.len = 3'd2;
        res.chars[0] = CH_BSLASH;
        code = b[7] ? CODE_REPLACE : {8'd0, b};
        case (b)
            CH_QUOTE: begin
                res.chars[1] = CH_QUOTE;
            end
            CH_BSLASH: begin
                res.chars[1] = CH_BSLASH;
            end
            CH_BS: begin
                res.chars[1] = CH_LOW_B;
            end
            CH_FF: begin
                res.chars[1] = CH_LOW_F;
            end
            CH_LF: begin
                res.chars[1] = CH_LOW_N;
            end
            CH_CR: begin
                res.chars[1] = CH_LOW_R;
            end
            CH_TAB: begin
                res.chars[1] = CH_LOW_T;
            end
            default: begin
                if (b inside {[PRINT_LO:PRINT_HI]}) begin
                    res.chars[0] = b;
                    res.len = 3'd1;
                end else begin
                    res.chars[1] = CH_LOW_U;
                    res.chars[2] = hex_char(code[15:12]);
                    res.chars[3] = hex_char(code[11:8]);
                    res.chars[4] = hex_char(code[7:4]);
                    res.chars[5] = hex_char(code[3:0]);
                    res.len = 3'd6;
                end
            end
        endcase
        return res;
    endfunction

endpackage

// ===== sv/jse_cfg.sv =====
// Configuration register block of the JSON string escaper: APB-style
// access to the output budget register. Depends on jse_pkg.
module jse_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [jse_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [jse_pkg::BUDGET_W-1:0] o_out_budget
);
    import jse_pkg::*;

    logic [BUDGET_W-1:0] r_out_budget;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_OUT_BUDGET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_budget <= BUDGET_RESET;
        end else if (wr_en) begin
            r_out_budget <= pwdata[BUDGET_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_OUT_BUDGET) ? {{(32-BUDGET_W){1'b0}}, r_out_budget} : 32'd0;
    assign o_out_budget = r_out_budget;

endmodule

// ===== sv/jse_core.sv =====
// Escape builder and budget tracking of the JSON string escaper: updates the
// remaining budget and stop flag for each accepted byte. Depends on jse_pkg.
module jse_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  jse_pkg::t_in_item            i_item,
    input  logic [jse_pkg::BUDGET_W-1:0] i_out_budget,
    output jse_pkg::t_seq                o_seq
);
    import jse_pkg::*;

    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] n_budget;
    logic                r_stop;
    logic                n_stop;
    logic [BUDGET_W-1:0] eff_budget;
    logic                eff_stop;
    logic                fits;
    t_escape             esc;

    always_comb begin
        esc = build_escape(i_item.in_byte);
        eff_budget = i_item.first_byte ? i_out_budget : r_budget;
        eff_stop = i_item.first_byte ? 1'b0 : r_stop;
        fits = eff_budget > {{(BUDGET_W-LEN_W){1'b0}}, esc.len};
        n_budget = eff_budget;
        n_stop = eff_stop;
        if (!eff_stop) begin
            if (fits) begin
                n_budget = eff_budget - {{(BUDGET_W-LEN_W){1'b0}}, esc.len};
            end else begin
                n_stop = 1'b1;
            end
        end
        o_seq.load = i_accept && !eff_stop && fits;
        o_seq.chars = esc.chars;
        o_seq.len = esc.len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
            r_stop <= 1'b0;
        end else if (i_accept) begin
            r_budget <= n_budget;
            r_stop <= n_stop;
        end
    end

endmodule

// ===== sv/jse_ser.sv =====
// Output serialiser of the JSON string escaper: holds one escape sequence
// and moves it character by character into the output register.
// Depends on jse_pkg.
module jse_ser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jse_pkg::t_seq      i_seq,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jse_pkg::t_out_item o_out
);
    import jse_pkg::*;

    logic [7:0]       r_chars [SEQ_MAX];
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_pos;
    logic             r_busy;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             move;
    logic             last;

    assign move = r_busy && (!r_out_valid || i_out_ready);
    assign last = (r_pos == (r_len - 3'd1));
    assign o_free = !r_busy || (move && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos <= '0;
        end else if (i_seq.load) begin
            r_busy <= 1'b1;
            r_pos <= '0;
        end else if (move) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq.load) begin
            for (int k = 0; k < SEQ_MAX; k++) begin
                r_chars[k] <= i_seq.chars[k];
            end
            r_len <= i_seq.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.out_char <= r_chars[r_pos];
            r_out.run_last <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule

// ===== sv/json_string_escaper.sv =====
// JSON string escaper, top level. An accepted byte's escape sequence is captured
// in the serialiser's character register, and its first character then moves
// into the single output register; a byte of L characters (one, two or six)
// then gives one character per cycle while the output is not stalled.
// Reset is synchronous and active low; budget register and remaining budget
// reset to 1024, the stop flag and all valid flags clear.
module json_string_escaper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  jse_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output jse_pkg::t_out_item            o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jse_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import jse_pkg::*;

    logic [BUDGET_W-1:0] out_budget;
    logic                accept;
    logic                free;
    t_seq                seq;

    assign o_in_ready = free;
    assign accept = i_in_valid && free;

    jse_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_out_budget (out_budget)
    );

    jse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (i_in),
        .i_out_budget (out_budget),
        .o_seq        (seq)
    );

    jse_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seq       (seq),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== sv/jse_checker.sv =====
// Port-level checker for the JSON string escaper and the bind that attaches
// it to the top level. Depends on jse_pkg and json_string_escaper.
module jse_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input jse_pkg::t_out_item          o_out,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [jse_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata
);
    import jse_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.run_last |=> o_out_valid)
        else $error("Escape run broken before its last character.");

    a_inner_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.run_last |->
            (o_out.out_char == CH_BSLASH) || (o_out.out_char == CH_LOW_U) ||
            (o_out.out_char == CH_ZERO) || (o_out.out_char == CH_ONE) ||
            (o_out.out_char == CH_SEVEN) || (o_out.out_char == CH_UP_F))
        else $error("Unexpected character inside an escape.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("Stalled output transaction changed.");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == REG_OUT_BUDGET) |=>
            (paddr[2] != REG_OUT_BUDGET) ||
            (prdata[BUDGET_W-1:0] == $past(pwdata[BUDGET_W-1:0])))
        else $error("Budget register read-back mismatch.");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
